// File: rtl/wftm_pkg.sv
// Package for the wildcard flow table: request/response structs, codes,
// wildcard bit positions and the match function. No dependencies.
`timescale 1ns / 1ps
package wftm_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam logic [15:0] EthTypeIp = 16'h0800;
  localparam logic [21:0] WcAll = 22'h3FFFFF;
  localparam int unsigned WcInPort = 0;
  localparam int unsigned WcEthSrc = 2;
  localparam int unsigned WcEthDst = 3;
  localparam int unsigned WcEthType = 4;
  localparam int unsigned WcProto = 5;
  localparam int unsigned WcL4Src = 6;
  localparam int unsigned WcL4Dst = 7;
  localparam int unsigned NwSrcShift = 8;
  localparam int unsigned NwDstShift = 14;
  localparam int unsigned WcTos = 21;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_ADD_DONE = 2'd0,
    ST_ADD_FULL = 2'd1,
    ST_HIT      = 2'd2,
    ST_MISS     = 2'd3
  } status_e;

  typedef struct packed {
    logic        req_type;
    logic [15:0] in_port;
    logic [47:0] eth_src;
    logic [47:0] eth_dst;
    logic [15:0] eth_type;
    logic [7:0]  ip_proto;
    logic [63:0] ip_addrs;
    logic [31:0] l4_ports;
    logic [7:0]  ip_tos;
    logic [21:0] wildcard_bits;
    logic [15:0] entry_priority_in;
    logic [15:0] action_port;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] fwd_port;
    logic [3:0]  entry_index;
  } rsp_t;

  // Prefix mask: count of ignored low bits, 32 or more ignores all.
  function automatic logic [31:0] prefix_mask(input logic [5:0] ign);
    logic [31:0] m;
    m = '0;
    if (ign < 6'd32) m = 32'hFFFF_FFFF << ign[4:0];
    return m;
  endfunction

  // Compare one stored entry against a packet header.
  function automatic logic entry_match(input req_t e, input req_t p);
    logic ok;
    logic [21:0] wc;
    wc = e.wildcard_bits;
    ok = 1'b1;
    if (!wc[WcInPort] && e.in_port != p.in_port) ok = 1'b0;
    if (!wc[WcEthSrc] && e.eth_src != p.eth_src) ok = 1'b0;
    if (!wc[WcEthDst] && e.eth_dst != p.eth_dst) ok = 1'b0;
    if (!wc[WcEthType] && e.eth_type != p.eth_type) ok = 1'b0;
    if (p.eth_type == EthTypeIp) begin
      if (!wc[WcProto] && e.ip_proto != p.ip_proto) ok = 1'b0;
      if (((e.ip_addrs[63:32] ^ p.ip_addrs[63:32]) &
           prefix_mask(wc[NwSrcShift +: 6])) != '0) ok = 1'b0;
      if (((e.ip_addrs[31:0] ^ p.ip_addrs[31:0]) &
           prefix_mask(wc[NwDstShift +: 6])) != '0) ok = 1'b0;
      if (!wc[WcL4Src] && e.l4_ports[31:16] != p.l4_ports[31:16]) ok = 1'b0;
      if (!wc[WcL4Dst] && e.l4_ports[15:0] != p.l4_ports[15:0]) ok = 1'b0;
      if (!wc[WcTos] && e.ip_tos != p.ip_tos) ok = 1'b0;
    end
    if (wc == WcAll) ok = 1'b1;
    return ok;
  endfunction

endpackage

// File: rtl/wftm_front.sv
// Front end: two-entry request queue between the input channel and the
// table engine. Depends on wftm_pkg.
`timescale 1ns / 1ps
module wftm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wftm_pkg::req_t  in_data_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output wftm_pkg::req_t  q_data_o
);
  import wftm_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  // Store incoming transaction
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/wftm_engine.sv
// Table engine: entry storage, add into first free slot, and a slot-serial
// lookup scan keeping the best match. Output register toward the result
// channel. Depends on wftm_pkg.
`timescale 1ns / 1ps
module wftm_engine #(
  parameter int unsigned TableDepth = wftm_pkg::TableDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  wftm_pkg::req_t  q_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wftm_pkg::rsp_t  out_data_o
);
  import wftm_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e              state_q, state_d;
  req_t                mem_q [TableDepth];
  req_t                rd_q;
  logic [CntW-1:0]     fill_q;
  logic [IdxW-1:0]     ptr_q;
  logic                rd_vld_q;
  logic [IdxW-1:0]     rd_idx_q;
  req_t                pkt_q;
  logic                found_q;
  logic [IdxW-1:0]     best_q;
  logic [15:0]         best_pr_q;
  logic [15:0]         best_port_q;
  logic                ov_q;
  rsp_t                od_q;
  logic                take, hit, last_rd, full;

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign full = (fill_q == CntW'(TableDepth));
  // Ready to take a request in idle when the output register is free
  assign q_ready_o = (state_q == S_IDLE) && !ov_q;
  assign take = q_valid_i && q_ready_o;
  assign hit = rd_vld_q && (!found_q || rd_q.entry_priority_in >= best_pr_q) &&
               entry_match(rd_q, pkt_q);
  assign last_rd = rd_vld_q && (CntW'(rd_idx_q) + 1'b1 == fill_q);

  // Entry memory: write on add, registered read during scan
  always_ff @(posedge clk_i) begin
    if (take && q_data_i.req_type == REQ_ADD && !full)
      mem_q[fill_q[IdxW-1:0]] <= q_data_i;
    rd_q <= mem_q[ptr_q];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (take && q_data_i.req_type == REQ_LOOKUP)
                state_d = (fill_q == '0) ? S_DONE : S_SCAN;
      S_SCAN: if (last_rd) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      rd_vld_q <= 1'b0;
      if (take) begin
        found_q <= 1'b0;
        ptr_q   <= '0;
        if (q_data_i.req_type == REQ_ADD) begin
          ov_q <= 1'b1;
          if (!full) fill_q <= fill_q + 1'b1;
        end
      end
      // Issue reads over filled slots
      if (state_q == S_SCAN) begin
        if (CntW'(ptr_q) < fill_q && !(rd_vld_q && last_rd)) begin
          rd_vld_q <= 1'b1;
          if (CntW'(ptr_q) + 1'b1 < fill_q) ptr_q <= ptr_q + 1'b1;
        end
        if (hit) found_q <= 1'b1;
      end
      if (state_q == S_DONE) ov_q <= 1'b1;
    end
  end

  // Payload registers: scan tracking and the response
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && rd_vld_q) rd_idx_q <= rd_idx_q + 1'b1;
    if (take) begin
      pkt_q    <= q_data_i;
      rd_idx_q <= '0;
      if (q_data_i.req_type == REQ_ADD) begin
        od_q.status      <= full ? ST_ADD_FULL : ST_ADD_DONE;
        od_q.fwd_port    <= '0;
        od_q.entry_index <= full ? 4'd0 : 4'(fill_q);
      end
    end
    if (state_q == S_SCAN && hit) begin
      best_q      <= rd_idx_q;
      best_pr_q   <= rd_q.entry_priority_in;
      best_port_q <= rd_q.action_port;
    end
    if (state_q == S_DONE) begin
      od_q.status      <= found_q ? ST_HIT : ST_MISS;
      od_q.fwd_port    <= found_q ? best_port_q : 16'd0;
      od_q.entry_index <= found_q ? 4'(best_q) : 4'd0;
    end
  end
endmodule

// File: rtl/wildcard_flow_table_match_top.sv
// Top level of the wildcard flow table. Instantiates wftm_front and
// wftm_engine; depends on wftm_pkg.
//
//  channel   | signals                      | payload
//  request   | in_valid_i / in_ready_o      | in_data_i  (req_t)
//  response  | out_valid_o / out_ready_i    | out_data_o (rsp_t)
//
// An add result is set in the engine's output register as the engine takes
// the request. For a lookup the engine scans the filled slots, skipping the
// scan on an empty table, and then sets the result in its done state; the
// engine reads one stored entry per cycle during the scan.
// The engine takes its next request in the cycle after its result is taken.
// Reset empties the table at once. A two-deep request queue keeps taking
// transactions while the engine works or the result waits, until it is full.
`timescale 1ns / 1ps
module wildcard_flow_table_match_top #(
  parameter int unsigned TableDepth = wftm_pkg::TableDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wftm_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wftm_pkg::rsp_t  out_data_o
);
  import wftm_pkg::*;

  logic q_valid, q_ready;
  req_t q_data;

  wftm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  wftm_engine #(.TableDepth(TableDepth)) u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule

// File: rtl/wftm_checker.sv
// Port-level checker for the flow table top level, bound to it below.
// Depends on wftm_pkg.
`timescale 1ns / 1ps
module wftm_port_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input wftm_pkg::rsp_t out_data_o
);
  import wftm_pkg::*;

  // Hold result while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Miss and full results carry zero port and index
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_MISS || out_data_o.status == ST_ADD_FULL)
    |-> out_data_o.fwd_port == '0 && out_data_o.entry_index == '0)
    else $error("nonzero fields on miss or full");

  // Add results carry zero port
  a_add_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_ADD_DONE |-> out_data_o.fwd_port == '0)
    else $error("add result with port");

  // No result appears straight after reset without a request
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result out of reset");
endmodule

bind wildcard_flow_table_match_top wftm_port_checker u_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_data_o
);
